@@ sv/lcdns_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, register indexes and constants shared by the character LCD nibble
// write sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

	// Request codes carried by an input item
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_INIT = 2'd1,
		OP_CMD  = 2'd2,
		OP_DATA = 2'd3
	} op_t;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_POWER = 3'd1,
		PH_SETUP = 3'd2,
		PH_PULSE = 3'd3,
		PH_GAP   = 3'd4,
		PH_EXTRA = 3'd5
	} phase_t;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] CFG_PULSE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CMD_GAP    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DATA_GAP   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_POWER_UP   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_INIT_STEP  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHORT      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR      = 3'd6;

	// Register reset values
	localparam logic [15:0] PULSE_RST     = 16'd25;
	localparam logic [23:0] CMD_GAP_RST   = 24'd1000;
	localparam logic [23:0] DATA_GAP_RST  = 24'd10000000;
	localparam logic [23:0] POWER_UP_RST  = 24'd3200;
	localparam logic [23:0] INIT_STEP_RST = 24'd30000;
	localparam logic [23:0] SHORT_RST     = 24'd800;
	localparam logic [23:0] CLEAR_RST     = 24'd10000;

	// Init step numbering: wake nibbles, then the command list
	localparam logic [3:0] STEP_WAKE_FIRST = 4'd1;
	localparam logic [3:0] STEP_WAKE_LAST  = 4'd4;
	localparam logic [3:0] STEP_CMD_FIRST  = 4'd5;
	localparam logic [3:0] STEP_CMD_LAST   = 4'd9;
	localparam logic [3:0] STEP_FUNC_SET   = 4'd5;
	localparam logic [3:0] STEP_CLEAR      = 4'd8;

	localparam logic [3:0] NIB_WAKE  = 4'h3;
	localparam logic [3:0] NIB_4BIT  = 4'h2;

	typedef struct packed {
		op_t        op;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic [3:0] bus_nibble;
		logic       register_select;
		logic       enable_line;
		logic       busy_res;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic [15:0] pulse_ticks;
		logic [23:0] command_gap_ticks;
		logic [23:0] data_gap_ticks;
		logic [23:0] power_up_ticks;
		logic [23:0] init_step_ticks;
		logic [23:0] short_ticks;
		logic [23:0] clear_ticks;
	} cfg_t;

	typedef struct packed {
		logic       en;
		logic       rs;
		logic [3:0] data;
	} pins_t;

	typedef struct packed {
		phase_t      phase;
		logic [23:0] wait_counter;
		logic [7:0]  pending_byte;
		logic [3:0]  init_index;
		logic        low_nibble_next;
		logic        select_latch;
		pins_t       pins;
	} state_t;

	// Init command list, addressed by init step
	function automatic logic [7:0] init_cmd(input logic [3:0] step);
		logic [7:0] cmd;
		unique case (step)
			4'd5:    cmd = 8'h28;
			4'd6:    cmd = 8'h0C;
			4'd7:    cmd = 8'h06;
			4'd8:    cmd = 8'h01;
			4'd9:    cmd = 8'h80;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

@@ sv/char_lcd_nibble_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD write sequencer for a 4-bit bus: init sequence, command and
// data bytes sent as two nibbles with an enable strobe, timed by tick items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  item    | in        | item_valid/item_stall | op, byte_value
//  result  | out       | result_valid/stall    | bus_nibble, register_select,
//          |           |                       | enable_line, busy_res, rejected
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  An item is taken into an input register, worked against the sequencer
//  state and written to the result register, one item per cycle sustained
//  while result_stall is low. The input register keeps taking items while
//  a result waits; result_stall backs up into item_stall only when both
//  registers are full. Reset clears the sequencer to idle with all pins low
//  and loads the timing registers with their defaults. cfg_ready is always
//  high.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  lcdns_pkg::item_t                  item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output lcdns_pkg::result_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcdns_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcdns_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lcdns_pkg::cfg_t    regs;
	lcdns_pkg::item_t   item_s1;
	logic               valid_s1;
	lcdns_pkg::state_t  st_q;
	lcdns_pkg::state_t  st_next;
	lcdns_pkg::result_t res_next;
	lcdns_pkg::result_t result_q;
	logic               result_valid_q;
	logic               advance;
	logic               take;

	lcdns_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	lcdns_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.regs    (regs),
		.st_next (st_next),
		.res     (res_next)
	);

	// Move the held item on when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= lcdns_pkg::PH_IDLE;
			st_q.wait_counter    <= 24'd0;
			st_q.pending_byte    <= 8'd0;
			st_q.init_index      <= 4'd0;
			st_q.low_nibble_next <= 1'b0;
			st_q.select_latch    <= 1'b0;
			st_q.pins            <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Result register: load on advance, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ sv/lcdns_cfg.sv @@
// ----------------------------------------------------------------------------
// lcdns_cfg
// Timing register file, written one register per transfer.
// ----------------------------------------------------------------------------
module lcdns_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lcdns_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lcdns_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lcdns_pkg::cfg_t                     regs
);

	lcdns_pkg::cfg_t regs_q;

	// Write the addressed register; unknown indexes drop the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pulse_ticks       <= lcdns_pkg::PULSE_RST;
			regs_q.command_gap_ticks <= lcdns_pkg::CMD_GAP_RST;
			regs_q.data_gap_ticks    <= lcdns_pkg::DATA_GAP_RST;
			regs_q.power_up_ticks    <= lcdns_pkg::POWER_UP_RST;
			regs_q.init_step_ticks   <= lcdns_pkg::INIT_STEP_RST;
			regs_q.short_ticks       <= lcdns_pkg::SHORT_RST;
			regs_q.clear_ticks       <= lcdns_pkg::CLEAR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lcdns_pkg::CFG_PULSE:     regs_q.pulse_ticks       <= cfg_data[15:0];
				lcdns_pkg::CFG_CMD_GAP:   regs_q.command_gap_ticks <= cfg_data;
				lcdns_pkg::CFG_DATA_GAP:  regs_q.data_gap_ticks    <= cfg_data;
				lcdns_pkg::CFG_POWER_UP:  regs_q.power_up_ticks    <= cfg_data;
				lcdns_pkg::CFG_INIT_STEP: regs_q.init_step_ticks   <= cfg_data;
				lcdns_pkg::CFG_SHORT:     regs_q.short_ticks       <= cfg_data;
				lcdns_pkg::CFG_CLEAR:     regs_q.clear_ticks       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ sv/lcdns_step.sv @@
// ----------------------------------------------------------------------------
// lcdns_step
// Next-state and result logic for one item: start a request from idle, or
// tick the wait counter and run through any phases whose wait ends in it.
// ----------------------------------------------------------------------------
module lcdns_step (
	input  lcdns_pkg::state_t  st,
	input  lcdns_pkg::item_t   item,
	input  lcdns_pkg::cfg_t    regs,
	output lcdns_pkg::state_t  st_next,
	output lcdns_pkg::result_t res
);

	logic rej;

	// Put one nibble on the bus with EN low
	function automatic lcdns_pkg::state_t begin_nibble(input lcdns_pkg::state_t s,
			input logic [3:0] nib);
		lcdns_pkg::state_t r;
		r = s;
		r.pins.data    = nib;
		r.pins.rs      = s.select_latch;
		r.pins.en      = 1'b0;
		r.phase        = lcdns_pkg::PH_SETUP;
		r.wait_counter = 24'd1;
		return r;
	endfunction

	// Latch a byte and start its high nibble
	function automatic lcdns_pkg::state_t begin_byte(input lcdns_pkg::state_t s,
			input logic [7:0] b);
		lcdns_pkg::state_t r;
		r = s;
		r.pending_byte    = b;
		r.low_nibble_next = 1'b0;
		return begin_nibble(r, b[7:4]);
	endfunction

	function automatic lcdns_pkg::state_t go_idle(input lcdns_pkg::state_t s);
		lcdns_pkg::state_t r;
		r = s;
		r.phase        = lcdns_pkg::PH_IDLE;
		r.wait_counter = 24'd0;
		r.init_index   = 4'd0;
		return r;
	endfunction

	// Extra wait done: advance the init step
	function automatic lcdns_pkg::state_t extra_done(input lcdns_pkg::state_t s);
		lcdns_pkg::state_t r;
		logic [3:0] step;
		r = s;
		step = s.init_index + 4'd1;
		r.init_index = step;
		if (step >= lcdns_pkg::STEP_WAKE_FIRST && step <= lcdns_pkg::STEP_WAKE_LAST) begin
			r = begin_nibble(r, (step == lcdns_pkg::STEP_WAKE_LAST) ?
				lcdns_pkg::NIB_4BIT : lcdns_pkg::NIB_WAKE);
		end else if (step >= lcdns_pkg::STEP_CMD_FIRST && step <= lcdns_pkg::STEP_CMD_LAST) begin
			r = begin_byte(r, lcdns_pkg::init_cmd(step));
		end else begin
			r = go_idle(r);
		end
		return r;
	endfunction

	// Byte gap done: init commands get their own extra wait
	function automatic lcdns_pkg::state_t gap_done(input lcdns_pkg::state_t s,
			input lcdns_pkg::cfg_t c);
		lcdns_pkg::state_t r;
		logic [23:0] extra;
		r = s;
		if (s.init_index == lcdns_pkg::STEP_FUNC_SET) begin
			extra = c.init_step_ticks;
		end else if (s.init_index == lcdns_pkg::STEP_CLEAR) begin
			extra = c.clear_ticks;
		end else begin
			extra = c.short_ticks;
		end
		if (s.init_index >= lcdns_pkg::STEP_CMD_FIRST &&
				s.init_index <= lcdns_pkg::STEP_CMD_LAST) begin
			r.phase        = lcdns_pkg::PH_EXTRA;
			r.wait_counter = extra;
			if (extra == 24'd0) begin
				r = extra_done(r);
			end
		end else begin
			r = go_idle(r);
		end
		return r;
	endfunction

	// Enable pulse done: wake nibbles wait, bytes go on to low nibble or gap
	function automatic lcdns_pkg::state_t pulse_done(input lcdns_pkg::state_t s,
			input lcdns_pkg::cfg_t c);
		lcdns_pkg::state_t r;
		logic [23:0] gap;
		r = s;
		r.pins.en = 1'b0;
		gap = s.select_latch ? c.data_gap_ticks : c.command_gap_ticks;
		if (s.init_index >= lcdns_pkg::STEP_WAKE_FIRST &&
				s.init_index <= lcdns_pkg::STEP_WAKE_LAST) begin
			r.phase        = lcdns_pkg::PH_EXTRA;
			r.wait_counter = c.init_step_ticks;
			if (c.init_step_ticks == 24'd0) begin
				r = extra_done(r);
			end
		end else if (!s.low_nibble_next) begin
			r.low_nibble_next = 1'b1;
			r = begin_nibble(r, s.pending_byte[3:0]);
		end else begin
			r.phase        = lcdns_pkg::PH_GAP;
			r.wait_counter = gap;
			if (gap == 24'd0) begin
				r = gap_done(r, c);
			end
		end
		return r;
	endfunction

	// Power-up wait done: first wake nibble
	function automatic lcdns_pkg::state_t power_done(input lcdns_pkg::state_t s);
		lcdns_pkg::state_t r;
		r = s;
		r.init_index      = lcdns_pkg::STEP_WAKE_FIRST;
		r.select_latch    = 1'b0;
		r.low_nibble_next = 1'b0;
		return begin_nibble(r, lcdns_pkg::NIB_WAKE);
	endfunction

	// Next state
	always_comb begin
		st_next = st;
		rej     = 1'b0;
		if (st.phase == lcdns_pkg::PH_IDLE) begin
			unique case (item.op)
				lcdns_pkg::OP_INIT: begin
					st_next.pins            = '0;
					st_next.select_latch    = 1'b0;
					st_next.low_nibble_next = 1'b0;
					st_next.init_index      = 4'd0;
					st_next.phase           = lcdns_pkg::PH_POWER;
					st_next.wait_counter    = regs.power_up_ticks;
					if (regs.power_up_ticks == 24'd0) begin
						st_next = power_done(st_next);
					end
				end
				lcdns_pkg::OP_CMD, lcdns_pkg::OP_DATA: begin
					st_next.init_index   = 4'd0;
					st_next.select_latch = (item.op == lcdns_pkg::OP_DATA);
					st_next = begin_byte(st_next, item.byte_value);
				end
				default: ;
			endcase
		end else begin
			rej = (item.op != lcdns_pkg::OP_TICK);
			if (st.wait_counter != 24'd0) begin
				st_next.wait_counter = st.wait_counter - 24'd1;
			end
			if (st_next.wait_counter == 24'd0) begin
				unique case (st.phase)
					lcdns_pkg::PH_POWER: st_next = power_done(st_next);
					lcdns_pkg::PH_SETUP: begin
						st_next.pins.en      = 1'b1;
						st_next.phase        = lcdns_pkg::PH_PULSE;
						st_next.wait_counter = (regs.pulse_ticks == 16'd0) ? 24'd1 :
							{8'd0, regs.pulse_ticks};
					end
					lcdns_pkg::PH_PULSE: st_next = pulse_done(st_next, regs);
					lcdns_pkg::PH_GAP:   st_next = gap_done(st_next, regs);
					lcdns_pkg::PH_EXTRA: st_next = extra_done(st_next);
					default: begin
						st_next.phase        = lcdns_pkg::PH_IDLE;
						st_next.wait_counter = 24'd0;
					end
				endcase
			end
		end
	end

	// Result: pins and status after this item
	always_comb begin
		res.bus_nibble      = st_next.pins.data;
		res.register_select = st_next.pins.rs;
		res.enable_line     = st_next.pins.en;
		res.busy_res        = (st_next.phase != lcdns_pkg::PH_IDLE);
		res.rejected        = rej;
	end

endmodule

@@ tb/sv/char_lcd_nibble_write_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_tb
// Self-checking bench for the 4-bit character LCD write sequencer. A short
// bring-up script with a few hand-computed results runs first. Then come
// two long-timing corner runs and randomized phases of init, command and
// data requests, padded by ticks and stray requests. A cycle-exact
// sequencer model predicts every result that the script does not pin,
// and the results are compared in order.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdns_pkg::*;

	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int PHASE_ITEMS   = 150;
	localparam int RESET_ROWS    = 2;
	localparam int SCRIPT_ROWS   = 18;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [23:0] TICKS_MAX = 24'hFFFFFF;

	// Commands the display gets after the wake nibbles, in order
	localparam logic [7:0] LCD_INIT_BYTES [0:4] = '{8'h28, 8'h0C, 8'h06, 8'h01, 8'h80};

	// Short timing used by the bring-up script
	localparam cfg_t BRINGUP_TIMING = '{16'd1, 24'd1, 24'd0, 24'd2, 24'd1, 24'd0, 24'd1};

	typedef struct packed {
		item_t   stim;
		logic    pinned;
		result_t want;
	} script_row_t;

	// Bring-up script: the first rows run with the reset timing
	localparam script_row_t BRINGUP [0:SCRIPT_ROWS-1] = '{
		'{'{OP_TICK, 8'h00}, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{'{OP_TICK, 8'hFF}, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{'{OP_DATA, 8'hFF}, 1'b1, '{4'hF, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{'{OP_CMD,  8'h00}, 1'b1, '{4'hF, 1'b1, 1'b1, 1'b1, 1'b1}},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_INIT, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'hAA}, 1'b0, '0},
		'{'{OP_CMD,  8'h00}, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_INIT, 8'h00}, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{'{OP_DATA, 8'h5A}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0},
		'{'{OP_TICK, 8'h00}, 1'b0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	item_t                  item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Sequencer model state and its copy of the timing registers
	cfg_t        timing;
	phase_t      seq_phase;
	logic [23:0] ticks_left;
	logic [7:0]  byte_out;
	logic [3:0]  init_step;
	logic        on_low_half;
	logic        rs_latch;
	pins_t       bus_pins;

	result_t     lcd_expect_q [$];
	logic        pin_ok;
	result_t     pin_want;
	logic        no_idle;
	int          mismatches;
	int          stalled_cycles;

	char_lcd_nibble_write_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Sequencer model
	// ------------------------------------------------------------------------
	function automatic void reset_sequencer();
		timing      = '{PULSE_RST, CMD_GAP_RST, DATA_GAP_RST, POWER_UP_RST,
		                INIT_STEP_RST, SHORT_RST, CLEAR_RST};
		seq_phase   = PH_IDLE;
		ticks_left  = '0;
		byte_out    = '0;
		init_step   = '0;
		on_low_half = 1'b0;
		rs_latch    = 1'b0;
		bus_pins    = '0;
	endfunction

	function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
	                                       input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_PULSE:     timing.pulse_ticks       = val[15:0];
			CFG_CMD_GAP:   timing.command_gap_ticks = val;
			CFG_DATA_GAP:  timing.data_gap_ticks    = val;
			CFG_POWER_UP:  timing.power_up_ticks    = val;
			CFG_INIT_STEP: timing.init_step_ticks   = val;
			CFG_SHORT:     timing.short_ticks       = val;
			CFG_CLEAR:     timing.clear_ticks       = val;
			default: ;
		endcase
	endfunction

	function automatic logic is_wake_step(input logic [3:0] s);
		return s >= STEP_WAKE_FIRST && s <= STEP_WAKE_LAST;
	endfunction

	function automatic logic is_cmd_step(input logic [3:0] s);
		return s >= STEP_CMD_FIRST && s <= STEP_CMD_LAST;
	endfunction

	// Put a nibble on the bus with EN low and wait one setup tick
	function automatic void drive_nibble(input logic [3:0] nib);
		bus_pins.data = nib;
		bus_pins.rs   = rs_latch;
		bus_pins.en   = 1'b0;
		seq_phase     = PH_SETUP;
		ticks_left    = 24'd1;
	endfunction

	function automatic void drive_byte(input logic [7:0] b);
		byte_out    = b;
		on_low_half = 1'b0;
		drive_nibble(b[7:4]);
	endfunction

	function automatic void go_idle();
		seq_phase  = PH_IDLE;
		ticks_left = '0;
		init_step  = '0;
	endfunction

	// Move on from a finished wait; zero-length waits fall straight through
	function automatic void close_wait();
		logic settled;
		settled = 1'b0;
		while (!settled) begin
			settled = 1'b1;
			case (seq_phase)
				PH_POWER: begin
					init_step   = STEP_WAKE_FIRST;
					rs_latch    = 1'b0;
					on_low_half = 1'b0;
					drive_nibble(NIB_WAKE);
				end
				PH_SETUP: begin
					bus_pins.en = 1'b1;
					seq_phase   = PH_PULSE;
					ticks_left  = (timing.pulse_ticks == '0) ? 24'd1 : {8'd0, timing.pulse_ticks};
				end
				PH_PULSE: begin
					bus_pins.en = 1'b0;
					if (is_wake_step(init_step)) begin
						seq_phase  = PH_EXTRA;
						ticks_left = timing.init_step_ticks;
						settled    = (ticks_left != '0);
					end else if (!on_low_half) begin
						on_low_half = 1'b1;
						drive_nibble(byte_out[3:0]);
					end else begin
						seq_phase  = PH_GAP;
						ticks_left = rs_latch ? timing.data_gap_ticks : timing.command_gap_ticks;
						settled    = (ticks_left != '0);
					end
				end
				PH_GAP: begin
					if (is_cmd_step(init_step)) begin
						seq_phase = PH_EXTRA;
						if (init_step == STEP_FUNC_SET)
							ticks_left = timing.init_step_ticks;
						else if (init_step == STEP_CLEAR)
							ticks_left = timing.clear_ticks;
						else
							ticks_left = timing.short_ticks;
						settled = (ticks_left != '0);
					end else begin
						go_idle();
					end
				end
				PH_EXTRA: begin
					init_step = init_step + 4'd1;
					if (is_wake_step(init_step))
						drive_nibble(init_step == STEP_WAKE_LAST ? NIB_4BIT : NIB_WAKE);
					else if (is_cmd_step(init_step))
						drive_byte(LCD_INIT_BYTES[3'(init_step - STEP_CMD_FIRST)]);
					else
						go_idle();
				end
				default: begin
					seq_phase  = PH_IDLE;
					ticks_left = '0;
				end
			endcase
		end
	endfunction

	// Advance the model by one accepted item and return the pin snapshot
	function automatic result_t predict_item(input item_t it);
		result_t r;
		logic    dropped;
		dropped = 1'b0;
		if (seq_phase == PH_IDLE) begin
			if (it.op == OP_INIT) begin
				bus_pins    = '0;
				rs_latch    = 1'b0;
				on_low_half = 1'b0;
				init_step   = '0;
				seq_phase   = PH_POWER;
				ticks_left  = timing.power_up_ticks;
				if (ticks_left == '0)
					close_wait();
			end else if (it.op == OP_CMD || it.op == OP_DATA) begin
				init_step = '0;
				rs_latch  = (it.op == OP_DATA);
				drive_byte(it.byte_value);
			end
		end else begin
			dropped = (it.op != OP_TICK);
			if (ticks_left != '0)
				ticks_left = ticks_left - 24'd1;
			if (ticks_left == '0)
				close_wait();
		end
		r.bus_nibble      = bus_pins.data;
		r.register_select = bus_pins.rs;
		r.enable_line     = bus_pins.en;
		r.busy_res        = (seq_phase != PH_IDLE);
		r.rejected        = dropped;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	function automatic void log_mismatch(input string what, input result_t want,
	                                     input result_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t %s: expected nib=%h rs=%b en=%b busy=%b rej=%b,",
			         $time, what, want.bus_nibble, want.register_select,
			         want.enable_line, want.busy_res, want.rejected,
			         " got nib=%h rs=%b en=%b busy=%b rej=%b",
			         got.bus_nibble, got.register_select, got.enable_line,
			         got.busy_res, got.rejected);
	endfunction

	// Track every transfer at the rising edge: check results, then predict
	always @(posedge clk) begin : scoreboard
		result_t want;
		result_t model_out;
		logic    moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				if (lcd_expect_q.size() == 0) begin
					log_mismatch("result with nothing expected", '0, result);
				end else begin
					want = lcd_expect_q.pop_front();
					if (result.bus_nibble !== want.bus_nibble ||
					    result.register_select !== want.register_select ||
					    result.enable_line !== want.enable_line ||
					    result.busy_res !== want.busy_res ||
					    result.rejected !== want.rejected)
						log_mismatch("result mismatch", want, result);
				end
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				apply_register(cfg_index, cfg_data);
			end
			if (item_valid && !item_stall) begin
				moved = 1'b1;
				model_out = predict_item(item);
				lcd_expect_q.push_back(pin_ok ? pin_want : model_out);
			end
			stalled_cycles = moved ? 0 : stalled_cycles + 1;
		end
	end

	// Give up when the channels stop moving
	initial begin : watchdog
		@(posedge arst_n);
		while (stalled_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	function automatic int draw_wait();
		if (no_idle)
			return 0;
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return $urandom_range(0, 2);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	// Hold off results for a random number of cycles per transfer
	initial begin : result_sink
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_wait();
			@(negedge clk);
			result_stall <= (hold != 0);
			if (hold != 0) begin
				repeat (hold) @(negedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
		end
	end

	// Present one item after a random gap and hold it until the transfer
	task automatic send_item(input item_t it, input logic pinned, input result_t want);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		pin_ok     <= pinned;
		pin_want   <= want;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (lcd_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Write the whole timing set once the item path is empty
	task automatic load_timing(input cfg_t s);
		logic [7:0] spare;
		spare = 8'($urandom_range(0, 255));
		drain_results();
		write_reg(CFG_PULSE, {spare, s.pulse_ticks});
		write_reg(CFG_CMD_GAP, s.command_gap_ticks);
		write_reg(CFG_DATA_GAP, s.data_gap_ticks);
		write_reg(CFG_POWER_UP, s.power_up_ticks);
		write_reg(CFG_INIT_STEP, s.init_step_ticks);
		write_reg(CFG_SHORT, s.short_ticks);
		write_reg(CFG_CLEAR, s.clear_ticks);
		write_reg(CFG_UNUSED, {spare, ~spare, spare});
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t pick_timing();
		cfg_t t;
		t.pulse_ticks       = 16'($urandom_range(0, 4));
		t.command_gap_ticks = 24'($urandom_range(0, 6));
		t.data_gap_ticks    = 24'($urandom_range(0, 6));
		t.power_up_ticks    = 24'($urandom_range(0, 8));
		t.init_step_ticks   = 24'($urandom_range(0, 4));
		t.short_ticks       = 24'($urandom_range(0, 3));
		t.clear_ticks       = 24'($urandom_range(0, 5));
		return t;
	endfunction

	// Mostly start sequences when idle and tick them through when busy
	function automatic item_t pick_item();
		item_t it;
		it.byte_value = 8'($urandom_range(0, 255));
		it.op         = OP_TICK;
		if (seq_phase == PH_IDLE) begin
			case ($urandom_range(0, 9))
				0, 1:    it.op = OP_TICK;
				2, 3:    it.op = OP_INIT;
				4, 5, 6: it.op = OP_CMD;
				default: it.op = OP_DATA;
			endcase
		end else if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 2))
				0:       it.op = OP_INIT;
				1:       it.op = OP_CMD;
				default: it.op = OP_DATA;
			endcase
		end
		return it;
	endfunction

	task automatic run_to_idle();
		item_t it;
		while (seq_phase != PH_IDLE) begin
			it.op         = OP_TICK;
			it.byte_value = 8'($urandom_range(0, 255));
			send_item(it, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int    n;
		int    k;
		int    p;
		int    counted;
		item_t it;
		cfg_t  s;

		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		pin_ok         = 1'b0;
		pin_want       = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		no_idle        = 1'b0;
		mismatches     = 0;
		stalled_cycles = 0;
		reset_sequencer();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Bring-up script, first with reset timing, then with short timing
		for (n = 0; n < SCRIPT_ROWS; n++) begin
			if (n == RESET_ROWS)
				load_timing(BRINGUP_TIMING);
			send_item(BRINGUP[n].stim, BRINGUP[n].pinned, BRINGUP[n].want);
		end
		run_to_idle();

		// Long enable pulse on a command; the waits it never uses at their maximum
		no_idle = 1'b1;
		s = '{16'd64, 24'd3, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX};
		load_timing(s);
		it.op         = OP_CMD;
		it.byte_value = 8'($urandom_range(0, 255));
		send_item(it, 1'b0, '0);
		run_to_idle();

		// Zero pulse on a data byte with the command gap at its maximum
		s = '{16'h0000, TICKS_MAX, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0};
		load_timing(s);
		it.op         = OP_DATA;
		it.byte_value = 8'($urandom_range(0, 255));
		send_item(it, 1'b0, '0);
		run_to_idle();
		no_idle = 1'b0;

		// Random phases; the first runs with every wait at zero
		counted = 0;
		p       = 0;
		while (counted < RANDOM_ITEMS) begin
			if (p == 0)
				s = '0;
			else
				s = pick_timing();
			load_timing(s);
			no_idle = (p % 4 == 3);
			k = 0;
			while (k < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
				it = pick_item();
				if (!(seq_phase == PH_IDLE && it.op == OP_TICK)) begin
					k++;
					counted++;
				end
				send_item(it, 1'b0, '0);
			end
			p++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
sv/lcdns_pkg.sv
sv/lcdns_cfg.sv
sv/lcdns_step.sv
sv/char_lcd_nibble_write_sequencer.sv
tb/sv/char_lcd_nibble_write_sequencer_tb.sv
